>>> hw/rtl/recursive_moving_average_adc_unit_macros.svh
// Assertion macros used by the checker file of the moving average unit.
// Depends on nothing; included by the checker module.
`ifndef RECURSIVE_MOVING_AVERAGE_ADC_UNIT_MACROS_SVH
`define RECURSIVE_MOVING_AVERAGE_ADC_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RMAA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rmaa check failed");

// The consequent must hold in the cycle after the antecedent.
`define RMAA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rmaa check failed");

`endif

>>> hw/rtl/rmaa_pkg.sv
// Types and constants of the recursive moving average unit.
// Depends on nothing; used by the top level and the checker.
package rmaa_pkg;

   localparam int SAMPLE_W  = 10;
   localparam int WL_W      = 5;
   localparam int FS_W      = 13;
   localparam int SUM_W     = 22;
   localparam int MV_W      = 13;
   localparam int SCALE_SH  = 10;
   localparam int PROD_W    = SUM_W + FS_W;
   localparam int DIV_W     = PROD_W - SCALE_SH;
   localparam int STEP_W    = $clog2(DIV_W);
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = FS_W;

   localparam logic [MV_W-1:0]      MV_MAX      = 13'd8191;
   localparam logic [WL_W-1:0]      WL_RESET    = 5'd10;
   localparam logic [FS_W-1:0]      FS_RESET    = 13'd5110;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FSCALE  = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_SUM,
      ST_UPDATE,
      ST_MULT,
      ST_DIV_MV,
      ST_FINISH
   } state_type;

endpackage

>>> hw/rtl/recursive_moving_average_adc_unit.sv
// Recursive moving average of 10-bit converter samples, scaled to millivolts.
// Depends on rmaa_pkg.
//
// One item is one sample and gives one result. The block holds a running sum and a
// sample count; during warm-up it adds and counts, afterwards it removes sum/W before
// adding the sample. A single restoring divider, one quotient bit per cycle over
// 25 steps, does both the sum/W division and the final division by the count, with
// one multiply by full_scale_mv between them. While the window fills an item goes to
// multiply, divide and finish; once full, sum/W divide and update come first. No new
// item is taken meanwhile. A finished result sits in an output register, so the next
// item is taken while it waits. CSR writes are taken at any time, one per cycle.
module recursive_moving_average_adc_unit #(
   parameter int MAX_WINDOW = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [rmaa_pkg::SAMPLE_W-1:0]      req_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [rmaa_pkg::MV_W-1:0]          rsp_average_mv,
   output logic                               rsp_window_full,
   input  logic                               csr_we,
   input  logic [rmaa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rmaa_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CNT_W = $clog2(MAX_WINDOW + 1);

   rmaa_pkg::state_type state_ff, state_in;

   logic [rmaa_pkg::WL_W-1:0]     window_length_ff;
   logic [rmaa_pkg::FS_W-1:0]     full_scale_ff;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [rmaa_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [rmaa_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic [rmaa_pkg::DIV_W-1:0]    qd_ff, qd_in;
   logic [CNT_W-1:0]              rem_ff, rem_in;
   logic [CNT_W-1:0]              divisor_ff, divisor_in;
   logic [rmaa_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rmaa_pkg::MV_W-1:0]     mv_ff, mv_in;
   logic                          full_ff, full_in;

   logic [CNT_W-1:0]              win;
   logic [31:0]                   wl_ext;
   logic [CNT_W:0]                trial;
   logic                          trial_ge;
   logic                          div_last;
   logic                          accept;
   logic [rmaa_pkg::PROD_W-1:0]   product;

   // Effective window: zero reads as one, large values saturate.
   always_comb begin
      wl_ext = 32'(window_length_ff);
      if (wl_ext == 32'd0) begin
         win = CNT_W'(1);
      end else if (wl_ext > 32'(MAX_WINDOW)) begin
         win = CNT_W'(MAX_WINDOW);
      end else begin
         win = CNT_W'(wl_ext);
      end
   end

   assign accept   = req_valid && (state_ff == rmaa_pkg::ST_IDLE);
   assign trial    = {rem_ff, qd_ff[rmaa_pkg::DIV_W-1]};
   assign trial_ge = (trial >= {1'b0, divisor_ff});
   assign div_last = (step_ff == '0);
   assign product  = rmaa_pkg::PROD_W'(sum_ff) * rmaa_pkg::PROD_W'(full_scale_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rmaa_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (count_ff < win) ? rmaa_pkg::ST_MULT : rmaa_pkg::ST_DIV_SUM;
            end
         end
         rmaa_pkg::ST_DIV_SUM: begin
            if (div_last) begin
               state_in = rmaa_pkg::ST_UPDATE;
            end
         end
         rmaa_pkg::ST_UPDATE: state_in = rmaa_pkg::ST_MULT;
         rmaa_pkg::ST_MULT:   state_in = rmaa_pkg::ST_DIV_MV;
         rmaa_pkg::ST_DIV_MV: begin
            if (div_last) begin
               state_in = rmaa_pkg::ST_FINISH;
            end
         end
         rmaa_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = rmaa_pkg::ST_IDLE;
            end
         end
         default: state_in = rmaa_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      count_in     = count_ff;
      sum_in       = sum_ff;
      sample_in    = sample_ff;
      qd_in        = qd_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      step_in      = step_ff;
      mv_in        = mv_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         rmaa_pkg::ST_IDLE: begin
            if (accept) begin
               sample_in = req_sample;
               if (count_ff < win) begin
                  sum_in   = sum_ff + rmaa_pkg::SUM_W'(req_sample);
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  qd_in      = rmaa_pkg::DIV_W'(sum_ff);
                  rem_in     = '0;
                  divisor_in = win;
                  step_in    = rmaa_pkg::STEP_W'(rmaa_pkg::DIV_W - 1);
               end
            end
         end
         rmaa_pkg::ST_DIV_SUM, rmaa_pkg::ST_DIV_MV: begin
            qd_in   = {qd_ff[rmaa_pkg::DIV_W-2:0], trial_ge};
            rem_in  = trial_ge ? CNT_W'(trial - {1'b0, divisor_ff}) : trial[CNT_W-1:0];
            step_in = step_ff - rmaa_pkg::STEP_W'(1);
         end
         rmaa_pkg::ST_UPDATE: begin
            sum_in   = sum_ff - qd_ff[rmaa_pkg::SUM_W-1:0] + rmaa_pkg::SUM_W'(sample_ff);
            count_in = win;
         end
         rmaa_pkg::ST_MULT: begin
            // Dividing by 1024 first leaves the floor of the full quotient unchanged.
            qd_in      = product[rmaa_pkg::PROD_W-1:rmaa_pkg::SCALE_SH];
            rem_in     = '0;
            divisor_in = count_ff;
            step_in    = rmaa_pkg::STEP_W'(rmaa_pkg::DIV_W - 1);
         end
         rmaa_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (qd_ff > rmaa_pkg::DIV_W'(rmaa_pkg::MV_MAX)) begin
                  mv_in = rmaa_pkg::MV_MAX;
               end else begin
                  mv_in = qd_ff[rmaa_pkg::MV_W-1:0];
               end
               full_in      = (count_ff >= win);
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= rmaa_pkg::ST_IDLE;
         count_ff         <= '0;
         sum_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
         window_length_ff <= rmaa_pkg::WL_RESET;
         full_scale_ff    <= rmaa_pkg::FS_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && (csr_index == rmaa_pkg::CSR_WINDOW)) begin
            window_length_ff <= csr_wdata[rmaa_pkg::WL_W-1:0];
         end
         if (csr_we && (csr_index == rmaa_pkg::CSR_FSCALE)) begin
            full_scale_ff <= csr_wdata[rmaa_pkg::FS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      qd_ff      <= qd_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      step_ff    <= step_in;
      mv_ff      <= mv_in;
      full_ff    <= full_in;
   end

   assign req_ready       = (state_ff == rmaa_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_average_mv  = mv_ff;
   assign rsp_window_full = full_ff;

endmodule

>>> hw/rtl/rmaa_checker.sv
// Port-level checks of the recursive moving average unit, bound to the top level.
// Depends on rmaa_pkg and the assertion macro header.
`include "recursive_moving_average_adc_unit_macros.svh"

module rmaa_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [rmaa_pkg::MV_W-1:0]          rsp_average_mv,
   input logic                               rsp_window_full
);

   logic req_take;
   logic rsp_stall;

   assign req_take  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // A stalled result stays offered and unchanged.
   `RMAA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid)
   `RMAA_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall,
                     $stable(rsp_average_mv) && $stable(rsp_window_full))
   // The block works on one item at a time.
   `RMAA_ASSERT_NEXT(a_busy_after_take, clock, reset, req_take, !req_ready)
   // No new result can appear in the cycle right after an item is taken.
   `RMAA_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_take, !$rose(rsp_valid))

endmodule

bind recursive_moving_average_adc_unit rmaa_checker u_rmaa_checker (.*);
